FILE: hw/rtl/midi_sample_dump_encoder_assert.svh
// Assertion macros shared by the encoder's checking code.
`ifndef MIDI_SAMPLE_DUMP_ENCODER_ASSERT_SVH
`define MIDI_SAMPLE_DUMP_ENCODER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MSDE_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MSDE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/msde_pkg.sv
package msde_pkg;

	localparam int ADDR_W = 6;
	localparam int DATA_W = 64;
	localparam int FIFO_DEPTH = 4;

	localparam logic [1:0] CMD_START = 2'd0;
	localparam logic [1:0] CMD_SAMPLE = 2'd1;
	localparam logic [1:0] CMD_FLUSH = 2'd2;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_BAD_CFG = 2'd1;
	localparam logic [1:0] ST_ORDER = 2'd2;

	localparam logic [2:0] REG_SLOT = 3'd0;
	localparam logic [2:0] REG_RATE = 3'd1;
	localparam logic [2:0] REG_COUNT = 3'd2;
	localparam logic [2:0] REG_LOOP_EN = 3'd3;
	localparam logic [2:0] REG_LOOP_START = 3'd4;
	localparam logic [2:0] REG_LOOP_END = 3'd5;
	localparam logic [2:0] REG_NAME = 3'd6;

	localparam logic [1:0] JOB_ERR = 2'd0;
	localparam logic [1:0] JOB_START = 2'd1;
	localparam logic [1:0] JOB_WORD = 2'd2;

	localparam logic [7:0] B_SOX = 8'hf0;
	localparam logic [7:0] B_EOX = 8'hf7;
	localparam logic [7:0] B_NONRT = 8'h7e;
	localparam logic [7:0] B_SPACE = 8'h20;
	localparam logic [29:0] PERIOD_NUM = 30'd1000000000;

	typedef struct packed {
		logic [1:0] command;
		logic signed [15:0] sample;
	} item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic last;
		logic [1:0] status;
		logic dump_done;
	} result_t;

	typedef struct packed {
		logic [6:0] slot;
		logic [19:0] sample_rate_hz;
		logic [20:0] sample_count;
		logic loop_enable;
		logic [20:0] loop_start;
		logic [20:0] loop_end;
		logic [63:0] name_text;
	} cfg_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [1:0] status;
		logic [20:0] word;
		logic open_pkt;
		logic close_pkt;
		logic done;
		logic [6:0] pkt_num;
	} job_t;

endpackage

FILE: hw/rtl/midi_sample_dump_encoder.sv
// MIDI Sample Dump encoder. Commands enter through a queue-style port (push/full) and the
// byte stream leaves through another (empty/pop), one byte per result transaction, each
// tagged with last, status and dump_done. A front end takes one command per cycle while
// the job queue has room, checks it against the configuration and the dump state, and
// places a job in a four-entry queue. The back end takes each job from the queue in its
// idle state, then emits one byte per cycle into a single output register, stalling
// whenever that register still holds a result that has not been popped. A sample or flush
// yields 3 bytes, plus 5 when it opens a packet and 2 when it closes one. A valid start
// first runs the bit-serial divider that forms the period, then emits the 34 bytes of the
// header and name messages. An error result is a single byte. Commands are accepted while
// the back end works until the job queue is full. Configuration registers sit on the APB
// port at byte address 8*i with 64-bit data.
`include "midi_sample_dump_encoder_assert.svh"

module midi_sample_dump_encoder import msde_pkg::*; #(
	parameter int WORDS_PER_PACKET = 40,
	parameter int NAME_BYTES = 8,
	parameter int SLOT_COUNT = 64
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input item_t item,
	output logic empty,
	input logic pop,
	output result_t result,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [ADDR_W-1:0] paddr,
	input logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic pready
);

	cfg_t cfg_q;
	logic job_push, fifo_full, job_valid, job_pop;
	job_t job_w, job_r;
	logic [2:0] reg_idx;

	assign pready = 1'b1;
	assign reg_idx = paddr[5:3];

	// Register writes complete on the access cycle of the transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.slot <= '0;
			cfg_q.sample_rate_hz <= 20'd44100;
			cfg_q.sample_count <= '0;
			cfg_q.loop_enable <= 1'b0;
			cfg_q.loop_start <= '0;
			cfg_q.loop_end <= '0;
			cfg_q.name_text <= '0;
		end else if (psel && penable && pwrite) begin
			case (reg_idx)
				REG_SLOT: cfg_q.slot <= pwdata[6:0];
				REG_RATE: cfg_q.sample_rate_hz <= pwdata[19:0];
				REG_COUNT: cfg_q.sample_count <= pwdata[20:0];
				REG_LOOP_EN: cfg_q.loop_enable <= pwdata[0];
				REG_LOOP_START: cfg_q.loop_start <= pwdata[20:0];
				REG_LOOP_END: cfg_q.loop_end <= pwdata[20:0];
				REG_NAME: cfg_q.name_text <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_SLOT: prdata = {57'd0, cfg_q.slot};
			REG_RATE: prdata = {44'd0, cfg_q.sample_rate_hz};
			REG_COUNT: prdata = {43'd0, cfg_q.sample_count};
			REG_LOOP_EN: prdata = {63'd0, cfg_q.loop_enable};
			REG_LOOP_START: prdata = {43'd0, cfg_q.loop_start};
			REG_LOOP_END: prdata = {43'd0, cfg_q.loop_end};
			REG_NAME: prdata = cfg_q.name_text;
			default: prdata = '0;
		endcase
	end

	msde_front #(
		.WORDS_PER_PACKET(WORDS_PER_PACKET),
		.SLOT_COUNT(SLOT_COUNT)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.item(item),
		.cfg(cfg_q),
		.fifo_full(fifo_full),
		.full(full),
		.job_push(job_push),
		.job(job_w)
	);

	msde_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.wr(job_push),
		.wdata(job_w),
		.rd(job_pop),
		.full(fifo_full),
		.valid(job_valid),
		.rdata(job_r)
	);

	msde_back #(
		.NAME_BYTES(NAME_BYTES)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.job_valid(job_valid),
		.job_in(job_r),
		.job_pop(job_pop),
		.pop(pop),
		.empty(empty),
		.result(result)
	);

	// Error results are single bytes of zero, and the closing byte of a dump is 0xf7.
	`MSDE_ASSERT_IMP(a_err_single, !empty && result.status != ST_OK, result.last && result.out_byte == 8'h00, "error result malformed")
	`MSDE_ASSERT_IMP(a_done_eox, !empty && result.dump_done, result.last && result.out_byte == B_EOX, "dump_done not on closing byte")
	`MSDE_ASSERT_NEXT(a_no_drop, !empty && !pop, !empty && $stable(result), "waiting result changed")

endmodule

FILE: hw/rtl/msde_front.sv
module msde_front import msde_pkg::*; #(
	parameter int WORDS_PER_PACKET = 40,
	parameter int SLOT_COUNT = 64
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	input item_t item,
	input cfg_t cfg,
	input logic fifo_full,
	output logic full,
	output logic job_push,
	output job_t job
);

	localparam int WIP_W = $clog2(WORDS_PER_PACKET + 1);

	typedef enum logic [1:0] {PH_IDLE, PH_ERROR, PH_STREAM, PH_DONE} phase_t;

	phase_t phase_q, phase_d;
	logic [20:0] sent_q, sent_d;
	logic [WIP_W-1:0] wip_q, wip_d, wip_inc;
	logic [6:0] pkt_q, pkt_d;
	logic bad;

	assign full = fifo_full;
	assign job_push = push && !fifo_full;
	assign wip_inc = wip_q + 1'b1;

	always_comb begin
		bad = (cfg.sample_count == 21'd0) || ({1'b0, cfg.slot} >= 8'(SLOT_COUNT)) ||
			(cfg.sample_rate_hz == 20'd0);
		if (!bad && cfg.loop_enable) begin
			bad = (cfg.loop_start > cfg.loop_end) || (cfg.loop_end > cfg.sample_count);
		end
	end

	always_comb begin
		phase_d = phase_q;
		sent_d = sent_q;
		wip_d = wip_q;
		pkt_d = pkt_q;
		job = '0;
		job.kind = JOB_ERR;
		job.status = ST_ORDER;
		job.pkt_num = pkt_q;
		job.open_pkt = (wip_q == '0);
		if (item.command == CMD_START) begin
			sent_d = '0;
			wip_d = '0;
			pkt_d = '0;
			if (bad) begin
				phase_d = PH_ERROR;
				job.status = ST_BAD_CFG;
			end else begin
				phase_d = PH_STREAM;
				job.kind = JOB_START;
				job.status = ST_OK;
			end
		end else if (item.command != CMD_SAMPLE && item.command != CMD_FLUSH) begin
			job.status = ST_ORDER;
		end else if (phase_q == PH_ERROR) begin
			job.status = ST_BAD_CFG;
		end else if (phase_q != PH_STREAM) begin
			job.status = ST_ORDER;
		end else if ((item.command == CMD_SAMPLE) == (sent_q < cfg.sample_count)) begin
			job.kind = JOB_WORD;
			job.status = ST_OK;
			if (item.command == CMD_SAMPLE) begin
				sent_d = sent_q + 21'd1;
				job.word = {~item.sample[15], item.sample[14:0], 5'd0};
			end
			wip_d = wip_inc;
			if (wip_inc >= WIP_W'(WORDS_PER_PACKET)) begin
				job.close_pkt = 1'b1;
				wip_d = '0;
				pkt_d = pkt_q + 7'd1;
				if (sent_d >= cfg.sample_count) begin
					job.done = 1'b1;
					phase_d = PH_DONE;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			sent_q <= '0;
			wip_q <= '0;
			pkt_q <= '0;
		end else if (job_push) begin
			phase_q <= phase_d;
			sent_q <= sent_d;
			wip_q <= wip_d;
			pkt_q <= pkt_d;
		end
	end

endmodule

FILE: hw/rtl/msde_fifo.sv
module msde_fifo import msde_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic wr,
	input job_t wdata,
	input logic rd,
	output logic full,
	output logic valid,
	output job_t rdata
);

	localparam int PTR_W = $clog2(FIFO_DEPTH);

	job_t mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wptr_q, rptr_q;
	logic [PTR_W:0] cnt_q;
	logic do_wr, do_rd;

	assign full = (cnt_q == (PTR_W+1)'(FIFO_DEPTH));
	assign valid = (cnt_q != '0);
	assign rdata = mem_q[rptr_q];
	assign do_wr = wr && !full;
	assign do_rd = rd && valid;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (do_rd) begin
				rptr_q <= rptr_q + 1'b1;
			end
			cnt_q <= cnt_q + (PTR_W+1)'(do_wr) - (PTR_W+1)'(do_rd);
		end
	end

endmodule

FILE: hw/rtl/msde_back.sv
module msde_back import msde_pkg::*; #(
	parameter int NAME_BYTES = 8
) (
	input logic clk,
	input logic arst_n,
	input cfg_t cfg,
	input logic job_valid,
	input job_t job_in,
	output logic job_pop,
	input logic pop,
	output logic empty,
	output result_t result
);

	typedef enum logic [1:0] {B_IDLE, B_DIV, B_EMIT} bstate_t;

	bstate_t state_q;
	job_t job_q;
	logic [5:0] idx_q, end_q;
	logic [4:0] dcnt_q;
	logic [20:0] rem_q, quo_q;
	logic [20:0] rem_sh;
	logic [6:0] chk_q;
	logic out_valid_q;
	result_t out_q;
	logic slot_free, is_last, emit_now;
	logic [7:0] byte_v;
	logic [31:0] name_v;
	logic [20:0] ls, le;

	function automatic logic [31:0] name_chars(input logic [63:0] raw);
		logic [31:0] acc;
		logic [2:0] n;
		logic [7:0] c;
		acc = {4{B_SPACE}};
		n = 3'd0;
		for (int i = 0; i < NAME_BYTES; i++) begin
			c = raw[8*i +: 8];
			if (c >= 8'h20 && c <= 8'h7e && n < 3'd4) begin
				if (c >= 8'h61 && c <= 8'h7a) begin
					c = c - 8'h20;
				end
				acc[8*n[1:0] +: 8] = c;
				n = n + 3'd1;
			end
		end
		return acc;
	endfunction

	assign name_v = name_chars(cfg.name_text);
	assign ls = cfg.loop_enable ? cfg.loop_start : 21'd0;
	assign le = cfg.loop_enable ? cfg.loop_end : 21'd0;
	assign slot_free = !out_valid_q || pop;
	assign emit_now = (state_q == B_EMIT) && slot_free;
	assign is_last = (idx_q == end_q);
	assign rem_sh = {rem_q[19:0], PERIOD_NUM[dcnt_q]};
	assign job_pop = (state_q == B_IDLE) && job_valid;
	assign empty = !out_valid_q;
	assign result = out_q;

	always_comb begin
		byte_v = 8'h00;
		if (job_q.kind == JOB_START) begin
			case (idx_q)
				6'd0, 6'd21: byte_v = B_SOX;
				6'd1: byte_v = B_NONRT;
				6'd3: byte_v = 8'h01;
				6'd4, 6'd28: byte_v = {1'b0, cfg.slot};
				6'd6: byte_v = 8'h10;
				6'd7: byte_v = {1'b0, quo_q[6:0]};
				6'd8: byte_v = {1'b0, quo_q[13:7]};
				6'd9: byte_v = {1'b0, quo_q[20:14]};
				6'd10: byte_v = {1'b0, cfg.sample_count[6:0]};
				6'd11: byte_v = {1'b0, cfg.sample_count[13:7]};
				6'd12: byte_v = {1'b0, cfg.sample_count[20:14]};
				6'd13: byte_v = {1'b0, ls[6:0]};
				6'd14: byte_v = {1'b0, ls[13:7]};
				6'd15: byte_v = {1'b0, ls[20:14]};
				6'd16: byte_v = {1'b0, le[6:0]};
				6'd17: byte_v = {1'b0, le[13:7]};
				6'd18: byte_v = {1'b0, le[20:14]};
				6'd19: byte_v = cfg.loop_enable ? 8'h00 : 8'h7f;
				6'd20, 6'd33: byte_v = B_EOX;
				6'd23: byte_v = B_SPACE;
				6'd24: byte_v = 8'h3c;
				6'd25: byte_v = 8'h02;
				6'd27: byte_v = 8'h73;
				6'd29: byte_v = name_v[7:0];
				6'd30: byte_v = name_v[15:8];
				6'd31: byte_v = name_v[23:16];
				6'd32: byte_v = name_v[31:24];
				default: byte_v = 8'h00;
			endcase
		end else if (job_q.kind == JOB_WORD) begin
			case (idx_q)
				6'd0: byte_v = B_SOX;
				6'd1: byte_v = B_NONRT;
				6'd3: byte_v = 8'h02;
				6'd4: byte_v = {1'b0, job_q.pkt_num};
				6'd5: byte_v = {1'b0, job_q.word[20:14]};
				6'd6: byte_v = {1'b0, job_q.word[13:7]};
				6'd7: byte_v = {1'b0, job_q.word[6:0]};
				6'd8: byte_v = {1'b0, chk_q};
				6'd9: byte_v = B_EOX;
				default: byte_v = 8'h00;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			out_valid_q <= 1'b0;
			idx_q <= '0;
			end_q <= '0;
			dcnt_q <= '0;
			chk_q <= '0;
			job_q <= '0;
			rem_q <= '0;
			quo_q <= '0;
			out_q <= '0;
		end else begin
			if (emit_now) begin
				out_valid_q <= 1'b1;
			end else if (pop && out_valid_q) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				B_IDLE: begin
					if (job_valid) begin
						job_q <= job_in;
						if (job_in.kind == JOB_START) begin
							state_q <= B_DIV;
							dcnt_q <= 5'd29;
							rem_q <= '0;
							quo_q <= '0;
							idx_q <= 6'd0;
							end_q <= 6'd33;
						end else begin
							state_q <= B_EMIT;
							if (job_in.kind == JOB_WORD) begin
								idx_q <= job_in.open_pkt ? 6'd0 : 6'd5;
								end_q <= job_in.close_pkt ? 6'd9 : 6'd7;
							end else begin
								idx_q <= 6'd0;
								end_q <= 6'd0;
							end
						end
					end
				end
				B_DIV: begin
					if (rem_sh >= {1'b0, cfg.sample_rate_hz}) begin
						rem_q <= rem_sh - {1'b0, cfg.sample_rate_hz};
						quo_q <= {quo_q[19:0], 1'b1};
					end else begin
						rem_q <= rem_sh;
						quo_q <= {quo_q[19:0], 1'b0};
					end
					if (dcnt_q == 5'd0) begin
						state_q <= B_EMIT;
					end
					dcnt_q <= dcnt_q - 5'd1;
				end
				B_EMIT: begin
					if (slot_free) begin
						out_q.out_byte <= byte_v;
						out_q.last <= is_last;
						out_q.status <= job_q.status;
						out_q.dump_done <= (job_q.kind == JOB_WORD) && job_q.done && is_last;
						if (job_q.kind == JOB_WORD) begin
							if (idx_q == 6'd4) begin
								chk_q <= B_NONRT[6:0] ^ 7'h02 ^ job_q.pkt_num;
							end else if (idx_q >= 6'd5 && idx_q <= 6'd7) begin
								chk_q <= chk_q ^ byte_v[6:0];
							end
						end
						idx_q <= idx_q + 6'd1;
						if (is_last) begin
							state_q <= B_IDLE;
						end
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

endmodule
